/* rtl/core/rhvc_pkg.sv */
package rhvc_pkg;

  // rtcp header fields
  localparam logic [1:0] RTCP_VERSION = 2'd2;
  localparam logic [7:0] PT_SR        = 8'd200;
  localparam logic [7:0] PT_MIN       = 8'd200;
  localparam logic [7:0] PT_MAX       = 8'd204;

  // width in bits of the sub-header chain position, counted in words
  localparam int unsigned NHP_W = 17;

  // verdict codes, first error found wins
  typedef enum logic [2:0] {
    ERR_OK      = 3'd0,
    ERR_SHORT   = 3'd1,
    ERR_FIRST   = 3'd2,
    ERR_CHAIN   = 3'd3,
    ERR_VERSION = 3'd4,
    ERR_PTYPE   = 3'd5,
    ERR_PAD     = 3'd6
  } rhvc_err_e;

  // one word of a datagram
  typedef struct packed {
    logic [31:0] data_word;
    logic [15:0] packet_bytes;
    logic        last_word;
  } rhvc_in_t;

  // one verdict
  typedef struct packed {
    logic       valid_res;
    logic [2:0] error_code;
  } rhvc_out_t;

  // handoff between the input register and the evaluation logic
  typedef struct packed {
    logic valid;
    logic last;
    logic advance;
  } rhvc_ctrl_t;

endpackage

/* rtl/core/rtcp_header_validity_check.sv */
// RTCP header validity check, streaming.
// Input channel (in_valid_i/in_ready_o/in_item_i): one transaction per 32-bit
// datagram word, first byte in bits 31:24, with the datagram byte length on
// every word and last_word set on the final word.
// Output channel (out_valid_o/out_ready_i/out_item_o): one transaction per
// datagram, issued for its last word: valid_res and error_code (0 ok,
// 1 too short, 2 compound first not SR/RR, 3 compound length mismatch,
// 4 version, 5 payload type, 6 padding).
// Throughput: one word per cycle, across datagrams, while verdicts are taken.
// Path: the last word is taken into the input register, where the check logic
// works on it, and the verdict enters the output register once that register
// is free.
// Reset empties both registers and clears the running state; the block then
// starts at the first word of a new datagram.
// When the receiver stalls, the verdict waits in the output register; words
// that are not last keep flowing, and a last word waits in the input
// register until the output register frees up.
module rtcp_header_validity_check #(
  parameter int unsigned MAX_PACKET_BYTES = 65535
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rhvc_pkg::rhvc_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rhvc_pkg::rhvc_out_t out_item_o
);
  import rhvc_pkg::*;

  logic       stage_valid;
  rhvc_in_t   stage_item;
  logic       load_ready;
  rhvc_out_t  verdict;
  rhvc_ctrl_t ctrl;

  // a word moves on unless it is last and the output register is full
  assign ctrl.valid   = stage_valid;
  assign ctrl.last    = stage_item.last_word;
  assign ctrl.advance = stage_valid && (!stage_item.last_word || load_ready);

  rhvc_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_item_i     (in_item_i),
    .advance_i     (ctrl.advance),
    .stage_valid_o (stage_valid),
    .stage_item_o  (stage_item)
  );

  rhvc_eval #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .item_i   (stage_item),
    .result_o (verdict)
  );

  rhvc_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (ctrl.valid && ctrl.last),
    .load_ready_o (load_ready),
    .load_item_i  (verdict),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

/* rtl/core/rhvc_in_stage.sv */
module rhvc_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rhvc_pkg::rhvc_in_t  in_item_i,
  input  logic                advance_i,
  output logic                stage_valid_o,
  output rhvc_pkg::rhvc_in_t  stage_item_o
);
  import rhvc_pkg::*;

  logic     vld_q, vld_d;
  rhvc_in_t item_q;
  logic     accept;

  // free when empty or when the held word moves on this cycle
  assign in_ready_o = !vld_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  // occupancy
  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign stage_valid_o = vld_q;
  assign stage_item_o  = item_q;

endmodule

/* rtl/core/rhvc_eval.sv */
module rhvc_eval #(
  parameter int unsigned MAX_PACKET_BYTES = 65535
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rhvc_pkg::rhvc_ctrl_t ctrl_i,
  input  rhvc_pkg::rhvc_in_t  item_i,
  output rhvc_pkg::rhvc_out_t result_o
);
  import rhvc_pkg::*;

  localparam int unsigned POS_MAX = (MAX_PACKET_BYTES - 1) / 4;
  localparam int unsigned POS_W   = $clog2(POS_MAX + 1);
  localparam logic [15:0] LEN_MAX = 16'(MAX_PACKET_BYTES);

  // running datagram state
  logic [POS_W-1:0] pos_q, pos_d;
  logic [NHP_W-1:0] nhp_q, nhp_d;
  logic             cmp_q, cmp_d;
  logic             stop_q, stop_d;
  logic             padf_q, padf_d;
  logic [15:0]      flen_q, flen_d;
  rhvc_err_e        err_q, err_d;

  logic [15:0]      len;
  logic [13:0]      end_w;
  logic [NHP_W-1:0] end_x;
  logic [31:0]      w;
  logic [1:0]       ver;
  logic             pad;
  logic [7:0]       pt;
  logic [15:0]      hlen;
  logic [NHP_W-1:0] hlen_p1;
  logic             first;

  logic             f_cmp;
  rhvc_err_e        f_err;
  logic             cur_cmp;
  rhvc_err_e        cur_err;
  logic             cur_padf;
  logic [15:0]      cur_flen;
  logic [NHP_W-1:0] cur_nhp;
  logic             chain_hit;
  logic [NHP_W-1:0] nhp_after;
  logic             stop_after;

  logic [1:0]       lane;
  logic [7:0]       padbyte;
  rhvc_err_e        code;

  // field extraction and length clamp
  assign w       = item_i.data_word;
  assign len     = (item_i.packet_bytes > LEN_MAX) ? LEN_MAX : item_i.packet_bytes;
  assign end_w   = len[15:2];
  assign end_x   = NHP_W'(end_w);
  assign ver     = w[31:30];
  assign pad     = w[29];
  assign pt      = w[23:16];
  assign hlen    = w[15:0];
  assign hlen_p1 = NHP_W'(hlen) + NHP_W'(1);
  assign first   = (pos_q == '0);

  // first header checks
  always_comb begin
    f_cmp = (len >= 16'd4) && (end_x > hlen_p1);
    priority if (len < 16'd4) begin
      f_err = ERR_SHORT;
    end else if (f_cmp) begin
      f_err = (ver != RTCP_VERSION || pad || (pt & 8'hFE) != PT_SR) ? ERR_FIRST : ERR_OK;
    end else if (ver != RTCP_VERSION) begin
      f_err = ERR_VERSION;
    end else if (pt < PT_MIN || pt > PT_MAX) begin
      f_err = ERR_PTYPE;
    end else begin
      f_err = ERR_OK;
    end
  end

  // state as seen after this word's first header update
  assign cur_cmp  = first ? f_cmp : cmp_q;
  assign cur_err  = first ? f_err : err_q;
  assign cur_padf = first ? pad : padf_q;
  assign cur_flen = first ? hlen : flen_q;
  assign cur_nhp  = (first && f_cmp) ? hlen_p1 : nhp_q;

  // compound sub-header chain walk
  assign chain_hit = !first && cmp_q && (err_q == ERR_OK) && !stop_q
                     && (NHP_W'(pos_q) == nhp_q) && (nhp_q < end_x);
  assign nhp_after  = (chain_hit && ver == RTCP_VERSION) ? nhp_q + hlen_p1 : cur_nhp;
  assign stop_after = stop_q || (chain_hit && ver != RTCP_VERSION);

  // padding byte lane of the last word
  assign lane = len[1:0] - 2'd1;
  always_comb begin
    unique case (lane)
      2'd0:    padbyte = w[31:24];
      2'd1:    padbyte = w[23:16];
      2'd2:    padbyte = w[15:8];
      default: padbyte = w[7:0];
    endcase
  end

  // verdict
  always_comb begin
    code = cur_err;
    if (cur_err == ERR_OK) begin
      if (cur_cmp) begin
        if (nhp_after != end_x) begin
          code = ERR_CHAIN;
        end
      end else if (cur_padf && (18'(padbyte) > {cur_flen, 2'b00})) begin
        code = ERR_PAD;
      end
    end
  end

  assign result_o.valid_res  = (code == ERR_OK);
  assign result_o.error_code = code;

  // next state, cleared after every verdict
  always_comb begin
    pos_d  = pos_q;
    nhp_d  = nhp_q;
    cmp_d  = cmp_q;
    stop_d = stop_q;
    padf_d = padf_q;
    flen_d = flen_q;
    err_d  = err_q;
    if (ctrl_i.advance) begin
      if (ctrl_i.last) begin
        pos_d  = '0;
        nhp_d  = '0;
        cmp_d  = 1'b0;
        stop_d = 1'b0;
        padf_d = 1'b0;
        flen_d = '0;
        err_d  = ERR_OK;
      end else begin
        pos_d  = (pos_q < POS_W'(POS_MAX)) ? pos_q + POS_W'(1) : pos_q;
        nhp_d  = nhp_after;
        cmp_d  = cur_cmp;
        stop_d = stop_after;
        padf_d = cur_padf;
        flen_d = cur_flen;
        err_d  = cur_err;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      nhp_q  <= '0;
      cmp_q  <= 1'b0;
      stop_q <= 1'b0;
      padf_q <= 1'b0;
      flen_q <= '0;
      err_q  <= ERR_OK;
    end else begin
      pos_q  <= pos_d;
      nhp_q  <= nhp_d;
      cmp_q  <= cmp_d;
      stop_q <= stop_d;
      padf_q <= padf_d;
      flen_q <= flen_d;
      err_q  <= err_d;
    end
  end

endmodule

/* rtl/core/rhvc_out_stage.sv */
module rhvc_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_valid_i,
  output logic                load_ready_o,
  input  rhvc_pkg::rhvc_out_t load_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rhvc_pkg::rhvc_out_t out_item_o
);
  import rhvc_pkg::*;

  logic      vld_q, vld_d;
  rhvc_out_t item_q;
  logic      load;

  // free when empty or when the held verdict is taken
  assign load_ready_o = !vld_q || out_ready_i;
  assign load         = load_valid_i && load_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= load_item_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_item_o  = item_q;

endmodule

/* rtl/core/rhvc_checker.sv */
module rhvc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input rhvc_pkg::rhvc_out_t out_item_o
);
  import rhvc_pkg::*;

  // a stalled verdict holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled verdict changed");

  // pass flag agrees with the code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.valid_res == (out_item_o.error_code == ERR_OK)))
    else $error("valid_res disagrees with error_code");

  // only defined codes leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.error_code <= ERR_PAD))
    else $error("undefined error code");

  // no verdict right after reset
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("verdict presented out of reset");

endmodule

bind rtcp_header_validity_check rhvc_checker u_rhvc_checker (.*);
